### hdl/assert_macros.svh
// assertion macros used by lpe_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic property, clocked and held off during reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal keeps its value in the cycle after cond
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error(msg);

`endif

### hdl/lpe_pkg.sv
// types, codes and helper functions of the legendre polynomial evaluator
// no dependencies
package lpe_pkg;

    localparam logic signed [63:0] S64_MIN = {1'b1, 63'b0};
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

    // configuration register indexes
    localparam logic CFG_DEGREE  = 1'b0;
    localparam logic CFG_EPSILON = 1'b1;

    typedef enum logic [1:0] {
        ALU_MUL_FX,
        ALU_MUL_INT,
        ALU_DIV_INT,
        ALU_DIV_FX
    } t_alu_op;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_FIN
    } t_alu_state;

    typedef struct packed {
        logic               start;
        t_alu_op            op;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic               done;
        logic               clip;
        logic signed [63:0] value;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_REC_INIT,
        S_REC_M1,
        S_REC_M2,
        S_REC_M3,
        S_REC_SUB,
        S_REC_DIV,
        S_REC_DONE,
        S_D_M1,
        S_D_SUB,
        S_D_M2,
        S_D_M3,
        S_D_SUB2,
        S_D_DIV,
        S_E_M1,
        S_E_M2,
        S_E_M3,
        S_E_SUB,
        S_E_M4,
        S_E_SUB2,
        S_E_DIV,
        S_FINISH
    } t_seq_state;

    typedef enum logic [1:0] {
        PH_VAL,
        PH_XM,
        PH_XG
    } t_phase;

    typedef struct packed {
        logic               clip;
        logic signed [63:0] val;
    } t_sres;

    // saturating subtract a - b
    function automatic t_sres sat_sub(input logic signed [63:0] a,
                                      input logic signed [63:0] b);
        t_sres              r;
        logic signed [63:0] d;
        d = a - b;
        r.clip = (a[63] != b[63]) && (d[63] != a[63]);
        r.val  = r.clip ? (a[63] ? S64_MIN : S64_MAX) : d;
        return r;
    endfunction

    // move x inward by 2*eps when it lies within eps of +1, then of -1
    function automatic logic signed [63:0] guard(input logic signed [63:0] x,
                                                 input logic [20:0]        eps,
                                                 input logic signed [63:0] one);
        logic signed [63:0] e;
        logic signed [63:0] d;
        logic signed [63:0] y;
        e = $signed({43'b0, eps});
        y = x;
        d = y - one;
        if ((d < 0 ? -d : d) < e) begin
            y = y - (e <<< 1);
        end
        d = y + one;
        if ((d < 0 ? -d : d) < e) begin
            y = y + (e <<< 1);
        end
        return y;
    endfunction

endpackage

### hdl/lpe_alu.sv
// shared multiply / divide unit: 32x32 partial products, bit-serial divide
// depends on lpe_pkg
module lpe_alu #(
    parameter int FRAC_BITS = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpe_pkg::t_alu_req i_req,
    output lpe_pkg::t_alu_rsp o_rsp
);

    localparam logic [127:0] RND = 128'd1 << (FRAC_BITS - 1);
    localparam logic [127:0] TOP = {64'b0, 1'b1, 63'b0};

    lpe_pkg::t_alu_state r_state, n_state;
    lpe_pkg::t_alu_op    r_op;
    logic                r_sa, r_neg;
    logic [63:0]         r_ma, r_mb;
    logic [127:0]        r_acc, r_num, r_q;
    logic [64:0]         r_rem;
    logic [6:0]          r_cnt;
    lpe_pkg::t_alu_rsp   r_rsp;

    logic [63:0]  mag_a, mag_b;
    logic [31:0]  pa, pb;
    logic [63:0]  prod;
    logic [127:0] addend;
    logic [64:0]  rem_sh, rem_next;
    logic         ge, rnd_up, is_div;
    logic [127:0] v;
    logic         f_clip;
    logic signed [63:0] f_val;

    assign mag_a  = i_req.a[63] ? (~i_req.a + 64'd1) : i_req.a;
    assign mag_b  = i_req.b[63] ? (~i_req.b + 64'd1) : i_req.b;
    assign is_div = (r_op == lpe_pkg::ALU_DIV_INT) || (r_op == lpe_pkg::ALU_DIV_FX);

    // partial product select
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin pa = r_ma[31:0];  pb = r_mb[31:0];  end
            2'd1: begin pa = r_ma[31:0];  pb = r_mb[63:32]; end
            2'd2: begin pa = r_ma[63:32]; pb = r_mb[31:0];  end
            default: begin pa = r_ma[63:32]; pb = r_mb[63:32]; end
        endcase
        prod = pa * pb;
        unique case (r_cnt[1:0])
            2'd0:    addend = {64'b0, prod};
            2'd3:    addend = {prod, 64'b0};
            default: addend = {32'b0, prod, 32'b0};
        endcase
    end

    // one restoring divide step
    assign rem_sh   = {r_rem[63:0], r_num[127]};
    assign ge       = rem_sh >= {1'b0, r_mb};
    assign rem_next = ge ? (rem_sh - {1'b0, r_mb}) : rem_sh;
    assign rnd_up   = r_rem >= ({1'b0, r_mb} - r_rem);

    // rounding and clipping of the finished magnitude
    always_comb begin
        unique case (r_op)
            lpe_pkg::ALU_MUL_FX:  v = (r_acc + RND) >> FRAC_BITS;
            lpe_pkg::ALU_MUL_INT: v = r_acc;
            default:              v = r_q + {127'b0, rnd_up};
        endcase
        if (is_div && (r_mb == 64'd0)) begin
            f_clip = 1'b1;
            f_val  = (r_ma == 64'd0) ? 64'sd0 : (r_sa ? lpe_pkg::S64_MIN : lpe_pkg::S64_MAX);
        end else if (r_neg) begin
            f_clip = v > TOP;
            f_val  = f_clip ? lpe_pkg::S64_MIN : $signed(~v[63:0] + 64'd1);
        end else begin
            f_clip = v >= TOP;
            f_val  = f_clip ? lpe_pkg::S64_MAX : $signed(v[63:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpe_pkg::ALU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpe_pkg::ALU_IDLE: begin
                if (i_req.start) begin
                    if ((i_req.op == lpe_pkg::ALU_MUL_FX) ||
                        (i_req.op == lpe_pkg::ALU_MUL_INT)) begin
                        n_state = lpe_pkg::ALU_MUL;
                    end else if (mag_b == 64'd0) begin
                        n_state = lpe_pkg::ALU_FIN;
                    end else begin
                        n_state = lpe_pkg::ALU_DIV;
                    end
                end
            end
            lpe_pkg::ALU_MUL: begin
                if (r_cnt[1:0] == 2'd3) n_state = lpe_pkg::ALU_FIN;
            end
            lpe_pkg::ALU_DIV: begin
                if (r_cnt == 7'd1) n_state = lpe_pkg::ALU_FIN;
            end
            default: n_state = lpe_pkg::ALU_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lpe_pkg::ALU_IDLE: begin
                if (i_req.start) begin
                    r_op  <= i_req.op;
                    r_sa  <= i_req.a[63];
                    r_neg <= i_req.a[63] ^ i_req.b[63];
                    r_ma  <= mag_a;
                    r_mb  <= mag_b;
                    r_acc <= '0;
                    r_num <= {mag_a, 64'b0};
                    r_rem <= '0;
                    r_q   <= '0;
                    unique case (i_req.op)
                        lpe_pkg::ALU_DIV_INT: r_cnt <= 7'd64;
                        lpe_pkg::ALU_DIV_FX:  r_cnt <= 7'(64 + FRAC_BITS);
                        default:              r_cnt <= 7'd0;
                    endcase
                end
            end
            lpe_pkg::ALU_MUL: begin
                r_acc <= r_acc + addend;
                r_cnt <= r_cnt + 7'd1;
            end
            lpe_pkg::ALU_DIV: begin
                r_rem <= rem_next;
                r_q   <= {r_q[126:0], ge};
                r_num <= {r_num[126:0], 1'b0};
                r_cnt <= r_cnt - 7'd1;
            end
            default: begin
                r_rsp.clip  <= f_clip;
                r_rsp.value <= f_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp.done <= 1'b0;
        end else begin
            r_rsp.done <= (r_state == lpe_pkg::ALU_FIN);
        end
    end

    assign o_rsp = r_rsp;

endmodule

### hdl/legendre_poly_eval.sv
// legendre polynomial evaluator, top level: sequencer, registers, ports
// depends on lpe_pkg and lpe_alu
//
// takes one sample x (signed, FRAC_BITS fraction bits) per word and returns
// P_n(x), P_n'(x) and P_n''(x) for the configured degree n, with a flag that
// is set when any intermediate value was clipped to the signed 64-bit range.
// all multiplies and divides run on one shared unit: a multiply built from
// four 32x32 partial products and a restoring divider that retires one
// quotient bit per cycle (64 bits for a divide by the step index,
// 64+FRAC_BITS bits for a fixed-point quotient). the recurrence runs three
// times (at x, at the guarded x and at the twice guarded x), each step being
// three products, a subtract and a divide by k. the time per word is
// dominated by the bit-serial divider; words of degree 0 and 1 skip the
// recurrence. the input stalls from acceptance until the result is moved
// into the output register, and the output register holds its word until
// the sink takes it, while the next sample can already be accepted. degree
// and edge_epsilon may be written only while no word is in flight; a degree
// above MAX_DEGREE counts as MAX_DEGREE.
module legendre_poly_eval #(
    parameter int MAX_DEGREE = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [20:0]        i_cfg_data,
    // sample channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_x_sample,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_poly_value,
    output logic signed [63:0] o_first_derivative,
    output logic signed [63:0] o_second_derivative,
    output logic               o_saturated
);

    localparam int KW = $clog2(MAX_DEGREE + 2);
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    // configuration registers
    logic [5:0]  r_degree;
    logic [20:0] r_eps;

    // sequencer and working registers
    lpe_pkg::t_seq_state r_state, n_state;
    lpe_pkg::t_phase     r_phase;
    logic                r_wait;
    logic                r_clip;
    logic [KW-1:0]       r_n, r_k;
    logic signed [63:0]  r_x, r_xm, r_rx;
    logic signed [63:0]  r_p0, r_p1, r_t, r_u, r_pnxm;
    logic signed [63:0]  r_val, r_d1, r_d2;

    // output register
    logic                r_out_valid;
    logic signed [63:0]  r_o_val, r_o_d1, r_o_d2;
    logic                r_o_sat;

    lpe_pkg::t_alu_req   w_req;
    lpe_pkg::t_alu_rsp   w_rsp;
    lpe_pkg::t_sres      w_sub;
    logic signed [63:0]  sub_a, sub_b;
    logic [KW-1:0]       w_n;
    logic [2*KW-1:0]     w_nn1;
    logic                w_issue;
    logic                accept;
    logic                out_free;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign w_n      = (int'(r_degree) > MAX_DEGREE) ? KW'(MAX_DEGREE) : KW'(r_degree);
    assign w_nn1    = (2*KW)'(r_n) * (2*KW)'(r_n + KW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 6'd0;
            r_eps    <= 21'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == lpe_pkg::CFG_DEGREE) begin
                r_degree <= i_cfg_data[5:0];
            end else begin
                r_eps <= i_cfg_data;
            end
        end
    end

    lpe_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // saturating subtract operands per state
    always_comb begin
        unique case (r_state)
            lpe_pkg::S_D_SUB:  begin sub_a = r_t; sub_b = r_p0; end
            lpe_pkg::S_D_SUB2: begin sub_a = r_u; sub_b = ONE;  end
            lpe_pkg::S_E_SUB2: begin sub_a = ONE; sub_b = r_u;  end
            default:           begin sub_a = r_t; sub_b = r_u;  end
        endcase
        w_sub = lpe_pkg::sat_sub(sub_a, sub_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and shared unit requests
    always_comb begin
        n_state   = r_state;
        w_issue   = 1'b0;
        w_req.op  = lpe_pkg::ALU_MUL_FX;
        w_req.a   = r_t;
        w_req.b   = r_u;
        unique case (r_state)
            lpe_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (w_n < KW'(2)) ? lpe_pkg::S_FINISH : lpe_pkg::S_REC_INIT;
                end
            end
            lpe_pkg::S_REC_INIT: n_state = lpe_pkg::S_REC_M1;
            lpe_pkg::S_REC_M1: begin
                w_issue = 1'b1;
                w_req.a = r_rx;
                w_req.b = r_p1;
                if (w_rsp.done) n_state = lpe_pkg::S_REC_M2;
            end
            lpe_pkg::S_REC_M2: begin
                w_issue  = 1'b1;
                w_req.op = lpe_pkg::ALU_MUL_INT;
                w_req.b  = $signed(64'({r_k, 1'b0} - (KW+1)'(1)));
                if (w_rsp.done) n_state = lpe_pkg::S_REC_M3;
            end
            lpe_pkg::S_REC_M3: begin
                w_issue  = 1'b1;
                w_req.op = lpe_pkg::ALU_MUL_INT;
                w_req.a  = r_p0;
                w_req.b  = $signed(64'(r_k - KW'(1)));
                if (w_rsp.done) n_state = lpe_pkg::S_REC_SUB;
            end
            lpe_pkg::S_REC_SUB: n_state = lpe_pkg::S_REC_DIV;
            lpe_pkg::S_REC_DIV: begin
                w_issue  = 1'b1;
                w_req.op = lpe_pkg::ALU_DIV_INT;
                w_req.b  = $signed(64'(r_k));
                if (w_rsp.done) begin
                    n_state = (r_k == r_n) ? lpe_pkg::S_REC_DONE : lpe_pkg::S_REC_M1;
                end
            end
            lpe_pkg::S_REC_DONE: begin
                n_state = (r_phase == lpe_pkg::PH_VAL) ? lpe_pkg::S_REC_INIT
                                                       : lpe_pkg::S_D_M1;
            end
            lpe_pkg::S_D_M1: begin
                w_issue = 1'b1;
                w_req.a = r_rx;
                w_req.b = r_p1;
                if (w_rsp.done) n_state = lpe_pkg::S_D_SUB;
            end
            lpe_pkg::S_D_SUB: n_state = lpe_pkg::S_D_M2;
            lpe_pkg::S_D_M2: begin
                w_issue  = 1'b1;
                w_req.op = lpe_pkg::ALU_MUL_INT;
                w_req.b  = $signed(64'(r_n));
                if (w_rsp.done) n_state = lpe_pkg::S_D_M3;
            end
            lpe_pkg::S_D_M3: begin
                w_issue = 1'b1;
                w_req.a = r_rx;
                w_req.b = r_rx;
                if (w_rsp.done) n_state = lpe_pkg::S_D_SUB2;
            end
            lpe_pkg::S_D_SUB2: n_state = lpe_pkg::S_D_DIV;
            lpe_pkg::S_D_DIV: begin
                w_issue  = 1'b1;
                w_req.op = lpe_pkg::ALU_DIV_FX;
                if (w_rsp.done) begin
                    n_state = (r_phase == lpe_pkg::PH_XG) ? lpe_pkg::S_E_M1
                                                          : lpe_pkg::S_REC_INIT;
                end
            end
            lpe_pkg::S_E_M1: begin
                w_issue = 1'b1;
                w_req.a = r_xm;
                w_req.b = r_t;
                if (w_rsp.done) n_state = lpe_pkg::S_E_M2;
            end
            lpe_pkg::S_E_M2: begin
                w_issue  = 1'b1;
                w_req.op = lpe_pkg::ALU_MUL_INT;
                w_req.b  = 64'sd2;
                if (w_rsp.done) n_state = lpe_pkg::S_E_M3;
            end
            lpe_pkg::S_E_M3: begin
                w_issue  = 1'b1;
                w_req.op = lpe_pkg::ALU_MUL_INT;
                w_req.a  = r_pnxm;
                w_req.b  = $signed(64'(w_nn1));
                if (w_rsp.done) n_state = lpe_pkg::S_E_SUB;
            end
            lpe_pkg::S_E_SUB: n_state = lpe_pkg::S_E_M4;
            lpe_pkg::S_E_M4: begin
                w_issue = 1'b1;
                w_req.a = r_xm;
                w_req.b = r_xm;
                if (w_rsp.done) n_state = lpe_pkg::S_E_SUB2;
            end
            lpe_pkg::S_E_SUB2: n_state = lpe_pkg::S_E_DIV;
            lpe_pkg::S_E_DIV: begin
                w_issue  = 1'b1;
                w_req.op = lpe_pkg::ALU_DIV_FX;
                if (w_rsp.done) n_state = lpe_pkg::S_FINISH;
            end
            default: begin
                if (out_free) n_state = lpe_pkg::S_IDLE;
            end
        endcase
        w_req.start = w_issue && !r_wait;
    end

    // one request outstanding at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= 1'b0;
        end else if (w_rsp.done) begin
            r_wait <= 1'b0;
        end else if (w_req.start) begin
            r_wait <= 1'b1;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_rsp.done) begin
            r_clip <= r_clip | w_rsp.clip;
        end
        unique case (r_state)
            lpe_pkg::S_IDLE: begin
                if (accept) begin
                    r_x     <= 64'(i_x_sample);
                    r_rx    <= 64'(i_x_sample);
                    r_n     <= w_n;
                    r_clip  <= 1'b0;
                    r_phase <= lpe_pkg::PH_VAL;
                    r_d2    <= 64'sd0;
                    if (w_n == KW'(0)) begin
                        r_val <= ONE;
                        r_d1  <= 64'sd0;
                    end else begin
                        r_val <= 64'(i_x_sample);
                        r_d1  <= ONE;
                    end
                end
            end
            lpe_pkg::S_REC_INIT: begin
                r_p0 <= ONE;
                r_p1 <= r_rx;
                r_k  <= KW'(2);
            end
            lpe_pkg::S_REC_M1, lpe_pkg::S_REC_M2, lpe_pkg::S_D_M1, lpe_pkg::S_D_M2,
            lpe_pkg::S_E_M1, lpe_pkg::S_E_M2: begin
                if (w_rsp.done) r_t <= w_rsp.value;
            end
            lpe_pkg::S_REC_M3, lpe_pkg::S_D_M3, lpe_pkg::S_E_M3, lpe_pkg::S_E_M4: begin
                if (w_rsp.done) r_u <= w_rsp.value;
            end
            lpe_pkg::S_REC_SUB, lpe_pkg::S_D_SUB, lpe_pkg::S_E_SUB: begin
                r_t    <= w_sub.val;
                r_clip <= r_clip | w_sub.clip;
            end
            lpe_pkg::S_D_SUB2, lpe_pkg::S_E_SUB2: begin
                r_u    <= w_sub.val;
                r_clip <= r_clip | w_sub.clip;
            end
            lpe_pkg::S_REC_DIV: begin
                if (w_rsp.done) begin
                    r_p0 <= r_p1;
                    r_p1 <= w_rsp.value;
                    r_k  <= r_k + KW'(1);
                end
            end
            lpe_pkg::S_REC_DONE: begin
                unique case (r_phase)
                    lpe_pkg::PH_VAL: begin
                        // value done, rerun the recurrence at the guarded x
                        r_val   <= r_p1;
                        r_xm    <= lpe_pkg::guard(r_x, r_eps, ONE);
                        r_rx    <= lpe_pkg::guard(r_x, r_eps, ONE);
                        r_phase <= lpe_pkg::PH_XM;
                    end
                    lpe_pkg::PH_XM: r_pnxm <= r_p1;
                    default: ;
                endcase
            end
            lpe_pkg::S_D_DIV: begin
                if (w_rsp.done) begin
                    if (r_phase == lpe_pkg::PH_XG) begin
                        r_t <= w_rsp.value;
                    end else begin
                        // first derivative done, guard once more for the second
                        r_d1    <= w_rsp.value;
                        r_rx    <= lpe_pkg::guard(r_xm, r_eps, ONE);
                        r_phase <= lpe_pkg::PH_XG;
                    end
                end
            end
            lpe_pkg::S_E_DIV: begin
                if (w_rsp.done) r_d2 <= w_rsp.value;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == lpe_pkg::S_FINISH) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lpe_pkg::S_FINISH) && out_free) begin
            r_o_val <= r_val;
            r_o_d1  <= r_d1;
            r_o_d2  <= r_d2;
            r_o_sat <= r_clip;
        end
    end

    assign o_in_stall          = (r_state != lpe_pkg::S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_poly_value        = r_o_val;
    assign o_first_derivative  = r_o_d1;
    assign o_second_derivative = r_o_d2;
    assign o_saturated         = r_o_sat;

endmodule

### hdl/lpe_checker.sv
// port-level checks of the legendre polynomial evaluator, bound to the top
// depends on assert_macros.svh and legendre_poly_eval
`include "assert_macros.svh"

module lpe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [63:0] o_poly_value,
    input logic signed [63:0] o_first_derivative,
    input logic signed [63:0] o_second_derivative,
    input logic               o_saturated
);

    // an accepted sample keeps the block busy in the next cycle
    `ASSERT_PROP(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input not stalled after accept")

    // a new result word only comes out of a busy sequencer
    `ASSERT_PROP(a_out_from_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result word without work in flight")

    // a stalled result word holds
    `ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, {o_out_valid, o_poly_value, o_first_derivative, o_second_derivative, o_saturated}, "stalled result word changed")

endmodule

bind legendre_poly_eval lpe_checker u_lpe_checker (.*);
